// ----- hdl/urng_pkg.sv -----
// urng_pkg: shared types and constants for the ultrasonic echo ranger.
// Holds the phase encoding, status codes, CSR indexes, field widths and
// register reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urng_pkg;

   // Field widths fixed by the register map and result format
   localparam int TRIG_W     = 8;
   localparam int TIMEOUT_W  = 14;
   localparam int SCALE_W    = 6;
   localparam int OFFSET_W   = 14;
   localparam int THRESH_W   = 20;
   localparam int STATUS_W   = 2;
   localparam int DIST_W     = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // Measurement phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_TRIG = 4'b0010,
      PH_WAIT = 4'b0100,
      PH_MEAS = 4'b1000
   } phase_type;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_ECHO  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_TICKS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_PER_TICK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_THRESHOLD = 3'd4;

   // CSR reset values
   localparam logic [TRIG_W-1:0]    TRIGGER_TICKS_RST   = 8'd15;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST   = 14'd10000;
   localparam logic [SCALE_W-1:0]   SCALE_PER_TICK_RST  = 6'd33;
   localparam logic [OFFSET_W-1:0]  DISTANCE_OFFSET_RST = 14'd3000;
   localparam logic [THRESH_W-1:0]  CLEAR_THRESHOLD_RST = 20'd25000;

endpackage

`default_nettype wire

// ----- hdl/ultrasonic_echo_ranger.sv -----
// ultrasonic_echo_ranger: time-of-flight ranging sequencer, one word per tick.
// Depends on urng_pkg for types, codes and register reset values.
`timescale 1ns / 1ps
`default_nettype none

// Each request word is one microsecond tick (start request and sampled echo
// level) and produces exactly one response word: trigger level, busy, done,
// status, distance in thousandths of a cm and a clear-ahead flag. One word is
// accepted every clock cycle while req_stall is low, into the input register;
// the result register then shows its response. The per-tick state update,
// the tick count times scale product and the threshold compare all sit
// between those two registers. The input register can take a new word while
// a response is held under rsp_stall, so req_stall only rises when both
// registers are full. CSRs should be written while no measurement is running.
module ultrasonic_echo_ranger #(
   parameter int COUNT_BITS = 15
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_start_req,
   input  wire                                   req_echo,
   // response channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_trigger,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic [urng_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [urng_pkg::DIST_W-1:0]    rsp_distance,
   output logic                                  rsp_clear_ahead,
   // CSR write port
   input  wire                                   csr_we,
   input  wire  [urng_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [urng_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // Compare width covers both the counter and the timeout register
   localparam int CW = (COUNT_BITS > urng_pkg::TIMEOUT_W) ? COUNT_BITS : urng_pkg::TIMEOUT_W;
   // Product and signed difference widths
   localparam int PW = COUNT_BITS + urng_pkg::SCALE_W;
   localparam int DW = ((PW > urng_pkg::THRESH_W) ? PW : urng_pkg::THRESH_W) + 2;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   // CSRs
   logic [urng_pkg::TRIG_W-1:0]    trigger_ticks_ff;
   logic [urng_pkg::TIMEOUT_W-1:0] timeout_ticks_ff;
   logic [urng_pkg::SCALE_W-1:0]   scale_per_tick_ff;
   logic [urng_pkg::OFFSET_W-1:0]  distance_offset_ff;
   logic [urng_pkg::THRESH_W-1:0]  clear_threshold_ff;

   // Input register
   logic s1_valid_ff, s1_valid_in;
   logic s1_start_ff, s1_echo_ff;

   // Sequencer state
   urng_pkg::phase_type   phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // Result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                trig_ff, trig_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [urng_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic signed [urng_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic                                clear_ff, clear_in;

   // Handshake
   logic req_accept, out_ready, s1_adv;

   // Datapath helpers
   logic [urng_pkg::TRIG_W-1:0] trig_len;
   logic [COUNT_BITS-1:0]       count_up;
   logic                        up_timed_out;
   logic                        len_reached;
   logic [PW-1:0]               prod;
   logic signed [DW-1:0]        dist_full;
   logic                        over_thresh;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv     = s1_valid_ff && out_ready;
   assign req_stall  = s1_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff   <= urng_pkg::TRIGGER_TICKS_RST;
         timeout_ticks_ff   <= urng_pkg::TIMEOUT_TICKS_RST;
         scale_per_tick_ff  <= urng_pkg::SCALE_PER_TICK_RST;
         distance_offset_ff <= urng_pkg::DISTANCE_OFFSET_RST;
         clear_threshold_ff <= urng_pkg::CLEAR_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            urng_pkg::CSR_TRIGGER_TICKS:
               trigger_ticks_ff <= csr_wdata[urng_pkg::TRIG_W-1:0];
            urng_pkg::CSR_TIMEOUT_TICKS:
               timeout_ticks_ff <= csr_wdata[urng_pkg::TIMEOUT_W-1:0];
            urng_pkg::CSR_SCALE_PER_TICK:
               scale_per_tick_ff <= csr_wdata[urng_pkg::SCALE_W-1:0];
            urng_pkg::CSR_DISTANCE_OFFSET:
               distance_offset_ff <= csr_wdata[urng_pkg::OFFSET_W-1:0];
            urng_pkg::CSR_CLEAR_THRESHOLD:
               clear_threshold_ff <= csr_wdata[urng_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // Trigger length, zero acts as one
   assign trig_len = (trigger_ticks_ff == '0) ? urng_pkg::TRIG_W'(1) : trigger_ticks_ff;

   // Saturating count and timeout test on the incremented count
   assign count_up     = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + COUNT_ONE;
   assign up_timed_out = (CW'(count_up) > CW'(timeout_ticks_ff)) || (count_up == COUNT_MAX);
   assign len_reached  = CW'(count_up) >= CW'(trig_len);

   // Distance = count * scale - offset, full precision for the threshold compare
   assign prod        = PW'(count_ff) * PW'(scale_per_tick_ff);
   assign dist_full   = signed'(DW'(prod)) - signed'(DW'(distance_offset_ff));
   assign over_thresh = dist_full > signed'(DW'(clear_threshold_ff));

   // Per-tick sequencer step
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      trig_in   = 1'b0;
      busy_in   = 1'b0;
      done_in   = 1'b0;
      status_in = urng_pkg::STATUS_OK;
      dist_in   = '0;
      clear_in  = 1'b0;
      unique case (phase_ff)
         urng_pkg::PH_IDLE: begin
            if (s1_start_ff) begin
               trig_in = 1'b1;
               busy_in = 1'b1;
               if (trig_len <= urng_pkg::TRIG_W'(1)) begin
                  phase_in = urng_pkg::PH_WAIT;
                  count_in = '0;
               end else begin
                  phase_in = urng_pkg::PH_TRIG;
                  count_in = COUNT_ONE;
               end
            end
         end
         urng_pkg::PH_TRIG: begin
            trig_in  = 1'b1;
            busy_in  = 1'b1;
            count_in = count_up;
            if (len_reached) begin
               phase_in = urng_pkg::PH_WAIT;
               count_in = '0;
            end
         end
         urng_pkg::PH_WAIT: begin
            busy_in = 1'b1;
            if (s1_echo_ff) begin
               // first high tick counts as one; zero timeout ends it at once
               if (timeout_ticks_ff == '0) begin
                  done_in   = 1'b1;
                  status_in = urng_pkg::STATUS_TOO_LONG;
                  phase_in  = urng_pkg::PH_IDLE;
                  count_in  = '0;
               end else begin
                  phase_in = urng_pkg::PH_MEAS;
                  count_in = COUNT_ONE;
               end
            end else if (up_timed_out) begin
               done_in   = 1'b1;
               status_in = urng_pkg::STATUS_NO_ECHO;
               phase_in  = urng_pkg::PH_IDLE;
               count_in  = '0;
            end else begin
               count_in = count_up;
            end
         end
         urng_pkg::PH_MEAS: begin
            busy_in = 1'b1;
            if (s1_echo_ff) begin
               if (up_timed_out) begin
                  done_in   = 1'b1;
                  status_in = urng_pkg::STATUS_TOO_LONG;
                  phase_in  = urng_pkg::PH_IDLE;
                  count_in  = '0;
               end else begin
                  count_in = count_up;
               end
            end else begin
               // echo fell: report
               done_in  = 1'b1;
               dist_in  = dist_full[urng_pkg::DIST_W-1:0];
               clear_in = over_thresh;
               phase_in = urng_pkg::PH_IDLE;
               count_in = '0;
            end
         end
         default: begin
            phase_in = urng_pkg::PH_IDLE;
            count_in = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= urng_pkg::PH_IDLE;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
         end
      end
   end

   // Input word register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_start_ff <= req_start_req;
         s1_echo_ff  <= req_echo;
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         trig_ff   <= trig_in;
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         status_ff <= status_in;
         dist_ff   <= dist_in;
         clear_ff  <= clear_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_trigger     = trig_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_status      = status_ff;
   assign rsp_distance    = dist_ff;
   assign rsp_clear_ahead = clear_ff;

endmodule

`default_nettype wire

// ----- hdl/urng_checker.sv -----
// urng_checker: port-level assertions for the ultrasonic echo ranger,
// bound to the top level. Depends on urng_pkg for status codes and widths.
`timescale 1ns / 1ps
`default_nettype none

module urng_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire                                rsp_trigger,
   input wire                                rsp_busy_res,
   input wire                                rsp_done_res,
   input wire [urng_pkg::STATUS_W-1:0]       rsp_status,
   input wire signed [urng_pkg::DIST_W-1:0]  rsp_distance,
   input wire                                rsp_clear_ahead
);

   // a finishing word or a trigger word always belongs to a measurement
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_done_res || rsp_trigger) |-> rsp_busy_res)
      else $error("done or trigger word without busy");

   // result fields are zero unless the word finishes a measurement
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |->
         rsp_status == urng_pkg::STATUS_OK && rsp_distance == '0 && !rsp_clear_ahead)
      else $error("result fields set on a non-finishing word");

   // timeouts carry no distance and no clear flag
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_status != urng_pkg::STATUS_OK |->
         rsp_distance == '0 && !rsp_clear_ahead)
      else $error("timeout word carries a distance");

   // a finishing word ends the trigger pulse
   a_done_no_trig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_trigger)
      else $error("trigger high on a finishing word");

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_trigger)
         && $stable(rsp_busy_res) && $stable(rsp_done_res) && $stable(rsp_status)
         && $stable(rsp_distance) && $stable(rsp_clear_ahead))
      else $error("stalled response word changed");

endmodule

bind ultrasonic_echo_ranger urng_checker u_urng_checker (.*);

`default_nettype wire
